### sv/agsb_pkg.sv
// shared constants and types for the aabb grid sector binner
package agsb_pkg;

    localparam int MAX_SIDE   = 64;
    localparam int SIDE_CFG_W = 7;
    localparam int SIDE_W     = $clog2(MAX_SIDE + 1);
    localparam int CELL_W     = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

    localparam int TAG_W   = 16;
    localparam int COORD_W = 32;
    localparam int HALF_W  = 31;
    localparam int RECIP_W = 32;
    localparam int IDX_W   = 12;

    localparam int N_CORNER = 4;
    localparam int CORNER_W = 2;
    localparam int CNT_W    = 3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int PROD_W = CELL_W + SIDE_W + 1;
    localparam int IXC_W  = (PROD_W > IDX_W) ? PROD_W : IDX_W;

    localparam logic signed [COORD_W-1:0] WORLD_MIN_RST = -32'sd524288;
    localparam logic [RECIP_W-1:0]        INV_SIZE_RST  = 32'd8192;
    localparam logic [SIDE_CFG_W-1:0]     SIDE_RST      = 7'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WORLD_MIN_X       = 3'd0,
        CFG_WORLD_MIN_Y       = 3'd1,
        CFG_INV_SECTOR_WIDTH  = 3'd2,
        CFG_INV_SECTOR_HEIGHT = 3'd3,
        CFG_SIDE_COUNT        = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [CELL_W-1:0] slot;
        logic              clamp;
    } t_axis_cell;

endpackage

### sv/aabb_grid_sector_binner.sv
// aabb grid sector binner: corners, cell lookup, sort, dedup and result emission
// throughput: a new item may enter every cycle while o_in_stall is low; each item yields 1 to 4
//   results that leave one per cycle while i_out_stall is low, so an item with several results
//   holds back the items behind it, set by the single result port behind the emission register
// reset: synchronous active low, clears the stage valid bits and the result count and
//   loads the configuration registers with their defaults
module aabb_grid_sector_binner (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [agsb_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [agsb_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [agsb_pkg::TAG_W-1:0]             i_body_number,
    input  logic signed [agsb_pkg::COORD_W-1:0]    i_center_x,
    input  logic signed [agsb_pkg::COORD_W-1:0]    i_center_y,
    input  logic [agsb_pkg::HALF_W-1:0]            i_half_width,
    input  logic [agsb_pkg::HALF_W-1:0]            i_half_height,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [agsb_pkg::TAG_W-1:0]             o_body_tag,
    output logic [agsb_pkg::IDX_W-1:0]             o_sector_index,
    output logic                                   o_clamped,
    output logic                                   o_last_of_run
);
    import agsb_pkg::*;

    localparam int NSTG = 7;

    // configuration
    logic signed [COORD_W-1:0] r_wmin_x, r_wmin_y;
    logic [RECIP_W-1:0]        r_inv_w, r_inv_h;
    logic [SIDE_CFG_W-1:0]     r_side_count;
    logic [SIDE_W-1:0]         eff_side;

    // pipeline control
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] en;
    logic            e_load;
    logic            out_acc;

    // stage payloads
    logic [TAG_W-1:0]          r_s0_tag, r_s1_tag, r_s2_tag, r_s3_tag, r_s4_tag,
                               r_s5_tag, r_s6_tag;
    logic signed [COORD_W-1:0] r_s0_cx, r_s0_cy;
    logic [HALF_W-1:0]         r_s0_hw, r_s0_hh;
    logic signed [COORD_W-1:0] r_s1_xs [2];
    logic signed [COORD_W-1:0] r_s1_ys [2];
    logic [COORD_W-1:0]        r_s2_xm [2];
    logic [COORD_W-1:0]        r_s2_ym [2];
    logic [1:0]                r_s2_xn, r_s2_yn;
    logic [COORD_W-1:0]        r_s3_xq [2];
    logic [COORD_W-1:0]        r_s3_yq [2];
    logic [1:0]                r_s3_xn, r_s3_yn;
    logic [CELL_W-1:0]         r_s4_col [2];
    logic [CELL_W-1:0]         r_s4_row [2];
    logic [1:0]                r_s4_xc, r_s4_yc;
    logic [IDX_W-1:0]          r_s5_idx [N_CORNER];
    logic [N_CORNER-1:0]       r_s5_clp;
    logic [IDX_W-1:0]          r_s6_idx [N_CORNER];
    logic [N_CORNER-1:0]       r_s6_clp;

    // combinational next values
    logic signed [COORD_W-1:0] n_s1_xs [2];
    logic signed [COORD_W-1:0] n_s1_ys [2];
    logic [COORD_W-1:0]        n_s2_xm [2];
    logic [COORD_W-1:0]        n_s2_ym [2];
    logic [1:0]                n_s2_xn, n_s2_yn;
    logic [COORD_W-1:0]        n_s3_xq [2];
    logic [COORD_W-1:0]        n_s3_yq [2];
    t_axis_cell                n_s4_x [2];
    t_axis_cell                n_s4_y [2];
    logic [IDX_W-1:0]          n_s5_idx [N_CORNER];
    logic [N_CORNER-1:0]       n_s5_clp;
    logic [IDX_W-1:0]          n_s6_idx [N_CORNER];
    logic [N_CORNER-1:0]       n_s6_clp;

    // emission register
    logic [TAG_W-1:0]    r_o_tag;
    logic [IDX_W-1:0]    r_o_idx [N_CORNER];
    logic [N_CORNER-1:0] r_o_clp;
    logic [CNT_W-1:0]    r_o_cnt;
    logic [IDX_W-1:0]    n_o_idx [N_CORNER];
    logic [N_CORNER-1:0] n_o_clp;
    logic [CNT_W-1:0]    n_o_cnt;

    function automatic logic signed [COORD_W-1:0] sat_add(
        input logic signed [COORD_W-1:0] c,
        input logic [HALF_W-1:0]         h,
        input logic                      sub
    );
        logic [COORD_W:0] a;
        logic [COORD_W:0] b;
        logic [COORD_W:0] s;
        a = {c[COORD_W-1], c};
        b = {{(COORD_W+1-HALF_W){1'b0}}, h};
        s = sub ? (a - b) : (a + b);
        if (s[COORD_W] != s[COORD_W-1]) begin
            sat_add = s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end else begin
            sat_add = s[COORD_W-1:0];
        end
    endfunction

    function automatic logic [COORD_W:0] offset_mag(
        input logic signed [COORD_W-1:0] c,
        input logic signed [COORD_W-1:0] w
    );
        logic [COORD_W:0] dp;
        logic [COORD_W:0] dn;
        dp = {c[COORD_W-1], c} - {w[COORD_W-1], w};
        dn = {w[COORD_W-1], w} - {c[COORD_W-1], c};
        // msb carries the sign, low bits the magnitude
        offset_mag = dp[COORD_W] ? {1'b1, dn[COORD_W-1:0]} : {1'b0, dp[COORD_W-1:0]};
    endfunction

    function automatic t_axis_cell axis_cell(
        input logic [COORD_W-1:0] q,
        input logic               neg,
        input logic [SIDE_W-1:0]  side
    );
        t_axis_cell r;
        logic [SIDE_W-1:0] top;
        top = side - SIDE_W'(1);
        if (neg) begin
            // less than one sector below the origin is still cell zero
            r.slot  = '0;
            r.clamp = (q != '0);
        end else if (q >= COORD_W'(side)) begin
            r.slot  = top[CELL_W-1:0];
            r.clamp = 1'b1;
        end else begin
            r.slot  = q[CELL_W-1:0];
            r.clamp = 1'b0;
        end
        axis_cell = r;
    endfunction

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wmin_x     <= WORLD_MIN_RST;
            r_wmin_y     <= WORLD_MIN_RST;
            r_inv_w      <= INV_SIZE_RST;
            r_inv_h      <= INV_SIZE_RST;
            r_side_count <= SIDE_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_WORLD_MIN_X:       r_wmin_x     <= i_cfg_data[COORD_W-1:0];
                CFG_WORLD_MIN_Y:       r_wmin_y     <= i_cfg_data[COORD_W-1:0];
                CFG_INV_SECTOR_WIDTH:  r_inv_w      <= i_cfg_data[RECIP_W-1:0];
                CFG_INV_SECTOR_HEIGHT: r_inv_h      <= i_cfg_data[RECIP_W-1:0];
                CFG_SIDE_COUNT:        r_side_count <= i_cfg_data[SIDE_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_side_count == '0) begin
            eff_side = SIDE_W'(1);
        end else if (int'(r_side_count) > MAX_SIDE) begin
            eff_side = SIDE_W'(MAX_SIDE);
        end else begin
            eff_side = SIDE_W'(r_side_count);
        end
    end

    // flow control: a stage moves when it is empty or the next one moves
    assign out_acc = o_out_valid && !i_out_stall;
    assign e_load  = (r_o_cnt == '0) || ((r_o_cnt == CNT_W'(1)) && out_acc);

    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || e_load;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_in_stall = !en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // corner sums, offsets, products, cells
    always_comb begin
        n_s1_xs[0] = sat_add(r_s0_cx, r_s0_hw, 1'b1);
        n_s1_xs[1] = sat_add(r_s0_cx, r_s0_hw, 1'b0);
        n_s1_ys[0] = sat_add(r_s0_cy, r_s0_hh, 1'b1);
        n_s1_ys[1] = sat_add(r_s0_cy, r_s0_hh, 1'b0);
        for (int i = 0; i < 2; i++) begin
            {n_s2_xn[i], n_s2_xm[i]} = offset_mag(r_s1_xs[i], r_wmin_x);
            {n_s2_yn[i], n_s2_ym[i]} = offset_mag(r_s1_ys[i], r_wmin_y);
            // integer part of the q.32 product
            n_s3_xq[i] = 32'((64'(r_s2_xm[i]) * 64'(r_inv_w)) >> 32);
            n_s3_yq[i] = 32'((64'(r_s2_ym[i]) * 64'(r_inv_h)) >> 32);
            n_s4_x[i]  = axis_cell(r_s3_xq[i], r_s3_xn[i], eff_side);
            n_s4_y[i]  = axis_cell(r_s3_yq[i], r_s3_yn[i], eff_side);
        end
    end

    // linear index per corner: bit 0 picks x, bit 1 picks y
    always_comb begin
        logic [IXC_W-1:0] lin;
        lin = '0;
        for (int i = 0; i < N_CORNER; i++) begin
            lin = IXC_W'(r_s4_row[i / 2]) * IXC_W'(eff_side) + IXC_W'(r_s4_col[i % 2]);
            n_s5_idx[i] = lin[IDX_W-1:0];
            n_s5_clp[i] = r_s4_xc[i % 2] | r_s4_yc[i / 2];
        end
    end

    // four-entry sorting network, three compare-exchange layers
    always_comb begin
        logic [IDX_W-1:0] t_i;
        logic             t_c;
        t_i = '0;
        t_c = 1'b0;
        n_s6_idx = r_s5_idx;
        n_s6_clp = r_s5_clp;
        if (n_s6_idx[0] > n_s6_idx[1]) begin
            t_i = n_s6_idx[0]; n_s6_idx[0] = n_s6_idx[1]; n_s6_idx[1] = t_i;
            t_c = n_s6_clp[0]; n_s6_clp[0] = n_s6_clp[1]; n_s6_clp[1] = t_c;
        end
        if (n_s6_idx[2] > n_s6_idx[3]) begin
            t_i = n_s6_idx[2]; n_s6_idx[2] = n_s6_idx[3]; n_s6_idx[3] = t_i;
            t_c = n_s6_clp[2]; n_s6_clp[2] = n_s6_clp[3]; n_s6_clp[3] = t_c;
        end
        if (n_s6_idx[0] > n_s6_idx[2]) begin
            t_i = n_s6_idx[0]; n_s6_idx[0] = n_s6_idx[2]; n_s6_idx[2] = t_i;
            t_c = n_s6_clp[0]; n_s6_clp[0] = n_s6_clp[2]; n_s6_clp[2] = t_c;
        end
        if (n_s6_idx[1] > n_s6_idx[3]) begin
            t_i = n_s6_idx[1]; n_s6_idx[1] = n_s6_idx[3]; n_s6_idx[3] = t_i;
            t_c = n_s6_clp[1]; n_s6_clp[1] = n_s6_clp[3]; n_s6_clp[3] = t_c;
        end
        if (n_s6_idx[1] > n_s6_idx[2]) begin
            t_i = n_s6_idx[1]; n_s6_idx[1] = n_s6_idx[2]; n_s6_idx[2] = t_i;
            t_c = n_s6_clp[1]; n_s6_clp[1] = n_s6_clp[2]; n_s6_clp[2] = t_c;
        end
    end

    // drop repeats, fold their clamp flags into the first of the run, pack to the front
    always_comb begin
        logic [N_CORNER-1:0] same;
        logic [N_CORNER-1:0] run_clp;
        logic [CNT_W-1:0]    pos;
        same    = '0;
        run_clp = '0;
        pos     = '0;
        for (int i = 1; i < N_CORNER; i++) begin
            same[i] = (r_s6_idx[i] == r_s6_idx[i-1]);
        end
        run_clp[N_CORNER-1] = r_s6_clp[N_CORNER-1];
        for (int i = N_CORNER - 2; i >= 0; i--) begin
            run_clp[i] = r_s6_clp[i] | (same[i+1] & run_clp[i+1]);
        end
        n_o_idx = r_s6_idx;
        n_o_clp = '0;
        for (int i = 0; i < N_CORNER; i++) begin
            if (!same[i]) begin
                n_o_idx[pos[CORNER_W-1:0]] = r_s6_idx[i];
                n_o_clp[pos[CORNER_W-1:0]] = run_clp[i];
                pos = pos + CNT_W'(1);
            end
        end
        n_o_cnt = pos;
    end

    // stage payload registers
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s0_tag <= i_body_number;
            r_s0_cx  <= i_center_x;
            r_s0_cy  <= i_center_y;
            r_s0_hw  <= i_half_width;
            r_s0_hh  <= i_half_height;
        end
        if (en[1]) begin
            r_s1_tag <= r_s0_tag;
            r_s1_xs  <= n_s1_xs;
            r_s1_ys  <= n_s1_ys;
        end
        if (en[2]) begin
            r_s2_tag <= r_s1_tag;
            r_s2_xm  <= n_s2_xm;
            r_s2_ym  <= n_s2_ym;
            r_s2_xn  <= n_s2_xn;
            r_s2_yn  <= n_s2_yn;
        end
        if (en[3]) begin
            r_s3_tag <= r_s2_tag;
            r_s3_xq  <= n_s3_xq;
            r_s3_yq  <= n_s3_yq;
            r_s3_xn  <= r_s2_xn;
            r_s3_yn  <= r_s2_yn;
        end
        if (en[4]) begin
            r_s4_tag <= r_s3_tag;
            for (int i = 0; i < 2; i++) begin
                r_s4_col[i] <= n_s4_x[i].slot;
                r_s4_row[i] <= n_s4_y[i].slot;
                r_s4_xc[i]  <= n_s4_x[i].clamp;
                r_s4_yc[i]  <= n_s4_y[i].clamp;
            end
        end
        if (en[5]) begin
            r_s5_tag <= r_s4_tag;
            r_s5_idx <= n_s5_idx;
            r_s5_clp <= n_s5_clp;
        end
        if (en[6]) begin
            r_s6_tag <= r_s5_tag;
            r_s6_idx <= n_s6_idx;
            r_s6_clp <= n_s6_clp;
        end
    end

    // emission register: results leave from entry 0 and the rest shift down
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_cnt <= '0;
        end else if (e_load) begin
            r_o_cnt <= r_vld[NSTG-1] ? n_o_cnt : '0;
        end else if (out_acc) begin
            r_o_cnt <= r_o_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_load) begin
            r_o_tag <= r_s6_tag;
            r_o_idx <= n_o_idx;
            r_o_clp <= n_o_clp;
        end else if (out_acc) begin
            for (int i = 0; i < N_CORNER - 1; i++) begin
                r_o_idx[i] <= r_o_idx[i+1];
                r_o_clp[i] <= r_o_clp[i+1];
            end
        end
    end

    assign o_out_valid    = (r_o_cnt != '0);
    assign o_body_tag     = r_o_tag;
    assign o_sector_index = r_o_idx[0];
    assign o_clamped      = r_o_clp[0];
    assign o_last_of_run  = (r_o_cnt == CNT_W'(1));

`ifndef SYNTHESIS
    a_run_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last_of_run) |=>
        (o_out_valid && (o_sector_index > $past(o_sector_index))
                     && (o_body_tag == $past(o_body_tag))))
        else $error("results of one item not strictly ascending or tag changed");

    a_sorted_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NSTG-1] |-> ((r_s6_idx[0] <= r_s6_idx[1]) && (r_s6_idx[1] <= r_s6_idx[2])
                          && (r_s6_idx[2] <= r_s6_idx[3])))
        else $error("sorted stage out of order");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_cnt <= CNT_W'(N_CORNER)))
        else $error("result count beyond corner count");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!o_out_valid && (r_vld == '0)))
        else $error("pipeline not empty after reset");
`endif

endmodule

### tb/sv/aabb_grid_sector_binner_tb.sv
// testbench for the aabb grid sector binner: directed and random boxes checked against a predictor
module aabb_grid_sector_binner_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import agsb_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_PRINTED = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNMAPPED = 3'd5;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
    localparam logic [HALF_W-1:0]         HALF_MAX  = 31'h7FFF_FFFF;

    typedef struct {
        logic [TAG_W-1:0]          tag;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [HALF_W-1:0]         hw;
        logic [HALF_W-1:0]         hh;
    } t_box;

    typedef struct {
        logic [TAG_W-1:0] tag;
        logic [IDX_W-1:0] idx;
        logic             clamped;
        logic             last;
    } t_sector;

    typedef struct packed {
        logic       clip;
        logic [6:0] slot;
    } t_axis;

    logic                         i_clk          = 1'b0;
    logic                         i_rst_n        = 1'b0;
    logic                         i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]         i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0]        i_cfg_data     = '0;
    logic                         i_in_valid     = 1'b0;
    logic                         o_in_stall;
    logic [TAG_W-1:0]             i_body_number  = '0;
    logic signed [COORD_W-1:0]    i_center_x     = '0;
    logic signed [COORD_W-1:0]    i_center_y     = '0;
    logic [HALF_W-1:0]            i_half_width   = '0;
    logic [HALF_W-1:0]            i_half_height  = '0;
    logic                         o_out_valid;
    logic                         i_out_stall    = 1'b0;
    logic [TAG_W-1:0]             o_body_tag;
    logic [IDX_W-1:0]             o_sector_index;
    logic                         o_clamped;
    logic                         o_last_of_run;

    // grid settings as the block should hold them
    logic signed [COORD_W-1:0] g_min_x = WORLD_MIN_RST;
    logic signed [COORD_W-1:0] g_min_y = WORLD_MIN_RST;
    logic [RECIP_W-1:0]        g_inv_w = INV_SIZE_RST;
    logic [RECIP_W-1:0]        g_inv_h = INV_SIZE_RST;
    logic [SIDE_CFG_W-1:0]     g_side  = SIDE_RST;

    t_sector pending_sectors[$];
    int      error_count   = 0;
    int      quiet_cycles  = 0;
    int      in_idle_pct   = 0;
    int      out_stall_pct = 0;
    int      stall_hold    = 0;

    aabb_grid_sector_binner dut (.*);

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic logic [6:0] grid_side();
        if (g_side == '0) return 7'd1;
        if (g_side > 7'(MAX_SIDE)) return 7'(MAX_SIDE);
        return g_side;
    endfunction

    function automatic logic signed [COORD_W-1:0] clip_coord(input longint v);
        if (v > 64'sd2147483647) return COORD_MAX;
        if (v < -64'sd2147483648) return COORD_MIN;
        return v[31:0];
    endfunction

    function automatic t_axis axis_cell(input logic signed [COORD_W-1:0] corner,
                                        input logic signed [COORD_W-1:0] wmin,
                                        input logic [RECIP_W-1:0] inv,
                                        input logic [6:0] side);
        longint      off;
        logic [63:0] mag;
        logic [63:0] prod;
        t_axis       r;
        off  = longint'(corner) - longint'(wmin);
        mag  = (off < 0) ? 64'(-off) : 64'(off);
        prod = mag * {32'd0, inv};
        r    = '0;
        // below the world minimum: less than one sector still counts as cell 0
        if (off < 0) begin
            r.clip = (prod[63:32] != 0);
        end else if (prod[63:32] >= {25'd0, side}) begin
            r.clip = 1'b1;
            r.slot = side - 7'd1;
        end else begin
            r.slot = prod[38:32];
        end
        return r;
    endfunction

    // corners to sorted, merged sector list
    function automatic void bin_box(input t_box b);
        logic signed [COORD_W-1:0] xs[2];
        logic signed [COORD_W-1:0] ys[2];
        logic [6:0]                side;
        t_axis                     col;
        t_axis                     row;
        logic [IDX_W-1:0]          idx[4];
        logic                      clp[4];
        logic [IDX_W-1:0]          kv;
        logic                      kf;
        t_sector                   runs[4];
        int                        n;
        int                        j;
        side  = grid_side();
        xs[0] = clip_coord(longint'(b.cx) - longint'(b.hw));
        xs[1] = clip_coord(longint'(b.cx) + longint'(b.hw));
        ys[0] = clip_coord(longint'(b.cy) - longint'(b.hh));
        ys[1] = clip_coord(longint'(b.cy) + longint'(b.hh));
        for (int i = 0; i < 4; i++) begin
            col    = axis_cell(xs[i % 2], g_min_x, g_inv_w, side);
            row    = axis_cell(ys[i / 2], g_min_y, g_inv_h, side);
            idx[i] = 12'(row.slot) * 12'(side) + 12'(col.slot);
            clp[i] = col.clip | row.clip;
        end
        for (int i = 1; i < 4; i++) begin
            kv = idx[i];
            kf = clp[i];
            j  = i - 1;
            while (j >= 0 && idx[j] > kv) begin
                idx[j + 1] = idx[j];
                clp[j + 1] = clp[j];
                j--;
            end
            idx[j + 1] = kv;
            clp[j + 1] = kf;
        end
        n = 0;
        for (int i = 0; i < 4; i++) begin
            if (n > 0 && runs[n - 1].idx == idx[i]) begin
                if (clp[i]) runs[n - 1].clamped = 1'b1;
            end else begin
                runs[n].tag     = b.tag;
                runs[n].idx     = idx[i];
                runs[n].clamped = clp[i];
                runs[n].last    = 1'b0;
                n++;
            end
        end
        runs[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++) pending_sectors.push_back(runs[i]);
    endfunction

    function automatic t_box make_box(input logic [TAG_W-1:0] tag,
                                      input logic signed [COORD_W-1:0] cx,
                                      input logic signed [COORD_W-1:0] cy,
                                      input logic [HALF_W-1:0] hw,
                                      input logic [HALF_W-1:0] hh);
        t_box b;
        b.tag = tag;
        b.cx  = cx;
        b.cy  = cy;
        b.hw  = hw;
        b.hh  = hh;
        return b;
    endfunction

    function automatic longint sector_raw(input logic [RECIP_W-1:0] inv);
        if (inv == '0) return 64'sd524288;
        return longint'((64'd1 << 32) / {32'd0, inv});
    endfunction

    // mostly around the grid, a little beyond each edge
    function automatic logic signed [COORD_W-1:0] pick_coord(
            input logic signed [COORD_W-1:0] wmin, input logic [RECIP_W-1:0] inv);
        longint span;
        longint off;
        span = sector_raw(inv) * longint'(grid_side());
        off  = longint'({$urandom, $urandom} % 64'(span + span / 4 + 1)) - span / 8;
        return clip_coord(longint'(wmin) + off);
    endfunction

    function automatic logic [HALF_W-1:0] pick_half(input logic [RECIP_W-1:0] inv);
        longint h;
        h = longint'({$urandom, $urandom} % 64'(sector_raw(inv) + 1)) >>> $urandom_range(3);
        if (h > 64'sd2147483647) h = 64'sd2147483647;
        return h[30:0];
    endfunction

    function automatic logic signed [COORD_W-1:0] edge_coord();
        case ($urandom_range(3))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2:       return '0;
            default: return -32'sd1;
        endcase
    endfunction

    function automatic t_box random_box();
        t_box b;
        int   mode;
        b.tag = 16'($urandom);
        mode  = $urandom_range(9);
        if (mode == 0) begin
            b.cx = $urandom;
            b.cy = $urandom;
            b.hw = 31'($urandom);
            b.hh = 31'($urandom);
        end else if (mode == 1) begin
            b.cx = edge_coord();
            b.cy = edge_coord();
            b.hw = $urandom_range(1) ? HALF_MAX : '0;
            b.hh = $urandom_range(1) ? HALF_MAX : '0;
        end else begin
            b.cx = pick_coord(g_min_x, g_inv_w);
            b.cy = pick_coord(g_min_y, g_inv_h);
            b.hw = pick_half(g_inv_w);
            b.hh = pick_half(g_inv_h);
        end
        return b;
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_PRINTED) $display("mismatch: %s", what);
    endtask

    task automatic send_box(input t_box b);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_body_number <= b.tag;
        i_center_x    <= b.cx;
        i_center_y    <= b.cy;
        i_half_width  <= b.hw;
        i_half_height <= b.hh;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        bin_box(b);
    endtask

    // stop offering items and wait until every expected sector is out
    task automatic drain_sectors();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_sectors.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (index)
            CFG_WORLD_MIN_X:       g_min_x = data;
            CFG_WORLD_MIN_Y:       g_min_y = data;
            CFG_INV_SECTOR_WIDTH:  g_inv_w = data;
            CFG_INV_SECTOR_HEIGHT: g_inv_h = data;
            CFG_SIDE_COUNT:        g_side  = data[SIDE_CFG_W-1:0];
            default: ;
        endcase
    endtask

    // block must be idle; ends with a write to an unmapped index that must change nothing
    task automatic load_grid(input logic signed [COORD_W-1:0] mx,
                             input logic signed [COORD_W-1:0] my,
                             input logic [RECIP_W-1:0] iw,
                             input logic [RECIP_W-1:0] ih,
                             input logic [SIDE_CFG_W-1:0] side);
        write_reg(CFG_WORLD_MIN_X, mx);
        write_reg(CFG_WORLD_MIN_Y, my);
        write_reg(CFG_INV_SECTOR_WIDTH, iw);
        write_reg(CFG_INV_SECTOR_HEIGHT, ih);
        write_reg(CFG_SIDE_COUNT, ($urandom & ~32'h7F) | {25'd0, side});
        write_reg(CFG_FIRST_UNMAPPED + 3'($urandom_range(2)), $urandom);
        i_cfg_we <= 1'b0;
    endtask

    // reset grid: 4 x 4 sectors of 2048.0 starting at -2048.0
    task automatic test_default_grid();
        send_box(make_box(16'h0000, 0, 0, 0, 0));
        send_box(make_box(16'hFFFF, 0, 0, 31'd300000, 31'd300000));
        send_box(make_box(16'h0001, 0, 0, 31'd300000, 0));
        send_box(make_box(16'h0002, -32'sd1, -32'sd1, 0, 0));
        // just under the world minimum, and more than a sector under it
        send_box(make_box(16'h0003, -32'sd524388, 0, 0, 0));
        send_box(make_box(16'h0004, -32'sd1124288, 0, 0, 0));
        send_box(make_box(16'h0005, 32'sd2000000, 32'sd2000000, 0, 0));
        // clamped and unclamped corners merging into one sector
        send_box(make_box(16'h0006, -32'sd1500000, 0, 31'd1000000, 0));
        send_box(make_box(16'h0007, COORD_MAX, COORD_MIN, HALF_MAX, HALF_MAX));
        send_box(make_box(16'h0008, COORD_MIN, COORD_MAX, HALF_MAX, HALF_MAX));
        send_box(make_box(16'h0009, 0, 0, HALF_MAX, HALF_MAX));
        send_box(make_box(16'hAAAA, 32'sh5555_5555, -32'sh5555_5556, 31'h2AAA_AAAA, 31'h5555_5555));
        send_box(make_box(16'h5555, -32'sh5555_5556, 32'sh5555_5555, 31'h5555_5555, 31'h2AAA_AAAA));
    endtask

    task automatic test_grid_extremes();
        for (int k = 0; k < 6; k++) begin
            drain_sectors();
            case (k)
                0: load_grid(WORLD_MIN_RST, WORLD_MIN_RST, INV_SIZE_RST, INV_SIZE_RST, 7'd0);
                1: load_grid(-32'sd2097152, -32'sd2097152, 32'h0001_0000, 32'h0001_0000, 7'd127);
                2: load_grid(0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd64);
                3: load_grid(WORLD_MIN_RST, -32'sd4096, INV_SIZE_RST, 32'h0010_0000, 7'd1);
                4: load_grid(COORD_MAX, COORD_MIN, 32'd0, 32'd0, 7'd64);
                default: load_grid(COORD_MIN, COORD_MAX, 32'd1, 32'h8000_0000, 7'd65);
            endcase
            send_box(make_box(16'($urandom), g_min_x, g_min_y, 0, 0));
            send_box(make_box(16'($urandom), 0, 0, HALF_MAX, HALF_MAX));
            repeat (10) send_box(random_box());
        end
    endtask

    task automatic test_random_traffic();
        int idle_plan[4];
        int stall_plan[4];
        idle_plan  = '{0, 48, 0, 9};
        stall_plan = '{0, 0, 48, 9};
        for (int p = 0; p < 4; p++) begin
            drain_sectors();
            in_idle_pct   = idle_plan[p];
            out_stall_pct = stall_plan[p];
            load_grid($urandom_range(3) == 0 ? 32'($urandom) : -32'($urandom_range(1 << 24)),
                      $urandom_range(3) == 0 ? 32'($urandom) : -32'($urandom_range(1 << 24)),
                      $urandom_range(4) == 0 ? 32'($urandom) : 32'($urandom_range(1 << 24)),
                      $urandom_range(4) == 0 ? 32'($urandom) : 32'($urandom_range(1 << 24)),
                      $urandom_range(5) == 0 ? 7'($urandom) : 7'($urandom_range(1, MAX_SIDE)));
            repeat (65) send_box(random_box());
        end
    endtask

    // receiver holds off long enough for the block to fill and stall its input
    task automatic test_output_backpressure();
        drain_sectors();
        in_idle_pct   = 0;
        out_stall_pct = 0;
        load_grid(-32'sd1048576, -32'sd1048576, 32'h0000_4000, 32'h0000_4000, 7'd8);
        stall_hold <= HOLD_CYCLES;
        repeat (30) send_box(random_box());
        drain_sectors();
        out_stall_pct = 20;
    endtask

    always @(posedge i_clk) begin
        if (stall_hold > 0) begin
            i_out_stall <= 1'b1;
            stall_hold  <= stall_hold - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    always @(posedge i_clk) begin : sector_check
        t_sector want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_sectors.size() == 0) begin
                report_mismatch($sformatf("unexpected sector %0d for body %0d",
                                          o_sector_index, o_body_tag));
            end else begin
                want = pending_sectors.pop_front();
                if (o_body_tag !== want.tag)
                    report_mismatch($sformatf("body tag %0d, want %0d", o_body_tag, want.tag));
                if (o_sector_index !== want.idx)
                    report_mismatch($sformatf("body %0d: sector %0d, want %0d",
                                              want.tag, o_sector_index, want.idx));
                if (o_clamped !== want.clamped)
                    report_mismatch($sformatf("body %0d sector %0d: clamped %0b, want %0b",
                                              want.tag, want.idx, o_clamped, want.clamped));
                if (o_last_of_run !== want.last)
                    report_mismatch($sformatf("body %0d sector %0d: last %0b, want %0b",
                                              want.tag, want.idx, o_last_of_run, want.last));
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_default_grid();
        test_grid_extremes();
        test_random_traffic();
        test_output_backpressure();
        drain_sectors();
        // catch anything extra the block might still send
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
sv/agsb_pkg.sv
sv/aabb_grid_sector_binner.sv
tb/sv/aabb_grid_sector_binner_tb.sv
